// ===== design/ale_pkg.sv =====
package ale_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int WORD_W = 32;
  localparam int POS_W = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_ERASE   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REVERSE = 3'd4,
    OP_READ    = 3'd5,
    OP_SORT    = 3'd6,
    OP_LENGTH  = 3'd7
  } opcode_t;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Datapath memory and count commands.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD_A,     // read mem[addr] into reg a
    DP_LOAD_B,     // read mem[addr] into reg b
    DP_WRITE_A,    // mem[addr] <= reg a
    DP_WRITE_B,    // mem[addr] <= reg b
    DP_WRITE_IN    // mem[addr] <= input word
  } dp_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

endpackage

// ===== design/ale_if.sv =====
interface ale_cmd_if;
  import ale_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [POS_W-1:0]   position;
  logic signed [WORD_W-1:0] word;
  modport source (output valid, opcode, position, word, input ready);
  modport sink   (input valid, opcode, position, word, output ready);
endinterface

interface ale_rsp_if;
  import ale_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] read_word;
  logic [POS_W-1:0]         length;
  modport source (output valid, status, read_word, length, input ready);
  modport sink   (input valid, status, read_word, length, output ready);
endinterface

// ===== design/ale_datapath.sv =====
module ale_datapath #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEFAULT,
  parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ale_pkg::dp_op_t              dp_op,
  input  logic [AW-1:0]                addr,
  input  ale_pkg::cnt_op_t             cnt_op,
  input  logic                         latch_word,
  input  logic [ale_pkg::WORD_W-1:0]   word_in,
  output logic [ale_pkg::WORD_W-1:0]   reg_a,
  output logic [ale_pkg::WORD_W-1:0]   reg_b,
  output logic [CW-1:0]                count
);
  import ale_pkg::*;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] word_q;
  logic              load_a_q, load_b_q;
  logic [WORD_W-1:0] rdata;

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (latch_word) word_q <= word_in;
    unique case (dp_op)
      DP_WRITE_A:  mem[addr] <= reg_a;
      DP_WRITE_B:  mem[addr] <= reg_b;
      DP_WRITE_IN: mem[addr] <= word_q;
      default: ;
    endcase
  end

  // Load flags are registered to line up with the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_a_q <= 1'b0;
      load_b_q <= 1'b0;
    end else begin
      load_a_q <= (dp_op == DP_LOAD_A);
      load_b_q <= (dp_op == DP_LOAD_B);
    end
  end

  always_ff @(posedge clk) begin
    if (load_a_q) reg_a <= rdata;
    if (load_b_q) reg_b <= rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        CNT_CLR: count <= '0;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ale_ctrl.sv =====
module ale_ctrl #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEFAULT,
  parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  ale_cmd_if.sink                      cmd,
  ale_rsp_if.source                    rsp,
  output ale_pkg::dp_op_t              dp_op,
  output logic [AW-1:0]                addr,
  output ale_pkg::cnt_op_t             cnt_op,
  output logic                         latch_word,
  input  logic [ale_pkg::WORD_W-1:0]   reg_a,
  input  logic [ale_pkg::WORD_W-1:0]   reg_b,
  input  logic [CW-1:0]                count
);
  import ale_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD, S_INS_WT, S_INS_WR, S_INS_PUT,
    S_ERA_RD, S_ERA_WT, S_ERA_WR,
    S_REV_RA, S_REV_RB, S_REV_WT, S_REV_WA,
    S_SRT_RA, S_SRT_RB, S_SRT_WT, S_SRT_CMP,
    S_RD_WT, S_RD_OUT
  } state_t;

  localparam int XW = CW + 1;

  state_t            state;
  logic [XW-1:0]     i, j;
  logic [XW-1:0]     pos_x, cnt_x;
  logic              rsp_pend;
  logic              b_less_a;
  logic              swap_wr;   // second write of a swap pending

  assign pos_x = XW'(cmd.position);
  assign cnt_x = XW'(count);
  assign b_less_a = $signed(reg_b) < $signed(reg_a);
  assign cmd.ready = (state == S_IDLE) && !rsp_pend && (!rsp.valid || rsp.ready);

  // Address follows the state; all indexes stay below CAPACITY when used.
  always_comb begin
    dp_op  = DP_NOP;
    cnt_op = CNT_HOLD;
    addr   = AW'(i);
    latch_word = cmd.valid && cmd.ready;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          unique case (opcode_t'(cmd.opcode))
            OP_CLEAR: cnt_op = CNT_CLR;
            OP_READ: begin
              addr = AW'(cmd.position);
              if (pos_x < cnt_x) dp_op = DP_LOAD_A;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD:  begin addr = AW'(i - XW'(1)); dp_op = DP_LOAD_A; end
      S_INS_WR:  begin addr = AW'(i); dp_op = DP_WRITE_A; end
      S_INS_PUT: begin addr = AW'(i); dp_op = DP_WRITE_IN; cnt_op = CNT_INC; end
      S_ERA_RD:  begin
        addr = AW'(i + XW'(1));
        dp_op = DP_LOAD_A;
        if (i + XW'(1) >= cnt_x) cnt_op = CNT_DEC;
      end
      S_ERA_WR:  begin addr = AW'(i); dp_op = DP_WRITE_A; end
      S_REV_RA:  begin addr = AW'(i); dp_op = DP_LOAD_A; end
      S_REV_RB:  begin addr = AW'(j); dp_op = DP_LOAD_B; end
      S_REV_WA:  begin
        addr = swap_wr ? AW'(j) : AW'(i);
        dp_op = swap_wr ? DP_WRITE_A : DP_WRITE_B;
      end
      S_SRT_RA:  begin addr = AW'(i); dp_op = DP_LOAD_A; end
      S_SRT_RB:  begin addr = AW'(j); dp_op = DP_LOAD_B; end
      S_SRT_CMP: begin
        if (swap_wr) begin
          addr = AW'(j); dp_op = DP_WRITE_A;
        end else if (b_less_a) begin
          addr = AW'(i); dp_op = DP_WRITE_B;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      rsp_pend  <= 1'b0;
      swap_wr   <= 1'b0;
      i <= '0;
      j <= '0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      // Every result is staged through rsp_pend so the reported length is current.
      if (rsp_pend) begin
        rsp.valid     <= 1'b1;
        rsp.length    <= POS_W'(count);
        rsp_pend      <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            rsp.status    <= ST_OK;
            rsp.read_word <= '0;
            unique case (opcode_t'(cmd.opcode))
              OP_APPEND: begin
                if (cnt_x >= XW'(CAPACITY)) rsp.status <= ST_FULL;
                else i <= cnt_x;
                if (cnt_x < XW'(CAPACITY)) state <= S_INS_PUT;
                else rsp_pend <= 1'b1;
              end
              OP_INSERT: begin
                if (pos_x > cnt_x) begin
                  rsp.status <= ST_RANGE; rsp_pend <= 1'b1;
                end else if (cnt_x >= XW'(CAPACITY)) begin
                  rsp.status <= ST_FULL; rsp_pend <= 1'b1;
                end else begin
                  i <= cnt_x; j <= pos_x;
                  state <= (cnt_x > pos_x) ? S_INS_RD : S_INS_PUT;
                end
              end
              OP_ERASE: begin
                if (pos_x >= cnt_x) begin
                  rsp.status <= ST_RANGE; rsp_pend <= 1'b1;
                end else begin
                  i <= pos_x;
                  state <= S_ERA_RD;
                end
              end
              OP_REVERSE: begin
                i <= '0; j <= cnt_x - XW'(1);
                if (cnt_x > XW'(1)) state <= S_REV_RA;
                else rsp_pend <= 1'b1;
              end
              OP_READ: begin
                if (pos_x >= cnt_x) begin
                  rsp.status <= ST_RANGE; rsp_pend <= 1'b1;
                end else state <= S_RD_WT;
              end
              OP_SORT: begin
                i <= '0; j <= XW'(1);
                if (cnt_x > XW'(1)) state <= S_SRT_RA;
                else rsp_pend <= 1'b1;
              end
              default: rsp_pend <= 1'b1;   // clear, length
            endcase
          end
        end
        // Read: the loaded word passes the registered read and reaches reg_a by S_RD_OUT.
        S_RD_WT: state <= S_RD_OUT;
        S_RD_OUT: begin
          rsp.read_word <= reg_a;
          rsp_pend <= 1'b1;
          state <= S_IDLE;
        end
        // Insert: shift down-to-up from count to position.
        S_INS_RD: state <= S_INS_WT;
        S_INS_WT: state <= S_INS_WR;
        S_INS_WR: begin
          i <= i - XW'(1);
          state <= (i - XW'(1) > j) ? S_INS_RD : S_INS_PUT;
        end
        S_INS_PUT: begin state <= S_IDLE; rsp_pend <= 1'b1; end
        // Erase: pull each later entry down one slot.
        S_ERA_RD: begin
          if (i + XW'(1) >= cnt_x) begin
            state <= S_IDLE; rsp_pend <= 1'b1;
          end else state <= S_ERA_WT;
        end
        S_ERA_WT: state <= S_ERA_WR;
        S_ERA_WR: begin i <= i + XW'(1); state <= S_ERA_RD; end
        S_REV_RA: state <= S_REV_RB;
        S_REV_RB: state <= S_REV_WT;
        S_REV_WT: state <= S_REV_WA;
        S_REV_WA: begin
          if (!swap_wr) swap_wr <= 1'b1;
          else begin
            swap_wr <= 1'b0;
            i <= i + XW'(1); j <= j - XW'(1);
            if (i + XW'(1) < j - XW'(1)) state <= S_REV_RA;
            else begin state <= S_IDLE; rsp_pend <= 1'b1; end
          end
        end
        S_SRT_RA: state <= S_SRT_RB;
        S_SRT_RB: state <= S_SRT_WT;
        S_SRT_WT: state <= S_SRT_CMP;
        S_SRT_CMP: begin
          if (b_less_a && !swap_wr) swap_wr <= 1'b1;
          else begin
            swap_wr <= 1'b0;
            if (j + XW'(1) < cnt_x) begin
              j <= j + XW'(1);
              state <= S_SRT_RA;
            end else if (i + XW'(2) < cnt_x) begin
              i <= i + XW'(1); j <= i + XW'(2);
              state <= S_SRT_RA;
            end else begin
              state <= S_IDLE; rsp_pend <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/array_list_engine_top.sv =====
// Channel   Dir  Payload                          Handshake
// cmd       in   opcode[3] position[6] word[32]   valid/ready
// rsp       out  status[2] read_word[32] length[6] valid/ready
//
// One command at a time. Clear, length and rejected commands respond from
// the accept, append after its write, read after its wait and output states;
// insert and erase move each shifted entry through read, wait and write;
// reverse swaps each pair, sort compares all n*(n-1)/2 pairs. The single-port
// entry memory with its registered read sets this sequence of states.
// Reset clears the count and the controller; entry contents are not cleared.
// A stalled response holds; the next command waits until it is taken.
module array_list_engine_top #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  ale_cmd_if.sink   cmd,
  ale_rsp_if.source rsp
);
  import ale_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  dp_op_t            dp_op;
  cnt_op_t           cnt_op;
  logic [AW-1:0]     addr;
  logic              latch_word;
  logic [WORD_W-1:0] reg_a, reg_b;
  logic [CW-1:0]     count;

  ale_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst, .cmd, .rsp, .dp_op, .addr, .cnt_op, .latch_word,
    .reg_a, .reg_b, .count
  );

  ale_datapath #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_dp (
    .clk, .rst, .dp_op, .addr, .cnt_op, .latch_word,
    .word_in(cmd.word), .reg_a, .reg_b, .count
  );

endmodule

module ale_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [ale_pkg::STATUS_W-1:0]    rsp_status,
  input logic [ale_pkg::WORD_W-1:0]      rsp_read_word,
  input logic [ale_pkg::POS_W-1:0]       rsp_length
);
  import ale_pkg::*;

  // Hold a stalled response steady.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_word) && $stable(rsp_length));

  // Drop request ready while a response is stalled.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !cmd_ready);

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE ||
      rsp_status == ST_FULL));

  a_read_word_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_read_word == '0);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid);

endmodule

bind array_list_engine_top ale_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_read_word (rsp.read_word),
  .rsp_length    (rsp.length)
);
